// File: sv/rip_pkg.sv
// Shared types and constants for the radix integer parser.
package rip_pkg;

   localparam logic [7:0]  CHAR_NUL   = 8'h00;
   localparam logic [7:0]  CHAR_MINUS = 8'h2D;
   localparam logic [7:0]  CHAR_PLUS  = 8'h2B;
   localparam logic [3:0]  HEX_TEN    = 4'hA;
   localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

   localparam logic [4:0]  RADIX_RESET  = 5'd10;
   localparam logic        SIGNED_RESET = 1'b1;

   // Register index of the configuration port, taken from the word address.
   typedef enum logic {
      REG_RADIX  = 1'b0,
      REG_SIGNED = 1'b1
   } reg_index_type;

   typedef enum logic {
      OP_ACC  = 1'b0,
      OP_EMIT = 1'b1
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic        clear;
      logic [3:0]  digit;
      logic        negate;
      logic [15:0] count;
   } op_type;

   typedef struct packed {
      logic valid;
      logic [3:0] value;
   } digit_type;

   function automatic digit_type digit_of(input logic [7:0] c);
      digit_type d;
      d.valid = 1'b1;
      d.value = 4'd0;
      if (c >= 8'h61 && c <= 8'h66) begin
         d.value = 4'(c - 8'h61) + HEX_TEN;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d.value = 4'(c - 8'h41) + HEX_TEN;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         d.value = 4'(c - 8'h30);
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

endpackage

// File: sv/rip_front.sv
// Front end: accepts characters, tracks the sign run and count, issues operations.
module rip_front
   import rip_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_first,
   input  logic [4:0]  radix,
   input  logic        signed_mode,
   input  logic        queue_full,
   output logic        push,
   output op_type      push_op
);

   typedef enum logic [2:0] {
      PH_DONE   = 3'b001,
      PH_SIGNS  = 3'b010,
      PH_DIGITS = 3'b100
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        negate_ff, negate_in;
   logic [15:0] count_ff, count_in;
   logic        clear_pend_ff, clear_pend_in;

   phase_type   cur_phase;
   logic        cur_negate;
   logic [15:0] cur_count;
   logic [15:0] count_inc;
   logic        cur_clear;
   logic        accept;
   logic        is_sign;
   logic        ends;
   digit_type   dig;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      // A start abandons any string in progress and clears the parse state.
      if (req_first) begin
         cur_phase  = signed_mode ? PH_SIGNS : PH_DIGITS;
         cur_negate = 1'b0;
         cur_count  = '0;
      end else begin
         cur_phase  = phase_ff;
         cur_negate = negate_ff;
         cur_count  = count_ff;
      end
      cur_clear = req_first || clear_pend_ff;
      count_inc = (cur_count == COUNT_MAX) ? cur_count : cur_count + 16'd1;
      dig       = digit_of(req_char_code);
      is_sign   = (req_char_code == CHAR_MINUS) || (req_char_code == CHAR_PLUS);
      ends      = (req_char_code == CHAR_NUL) || !dig.valid || ({1'b0, dig.value} >= radix);

      phase_in      = phase_ff;
      negate_in     = negate_ff;
      count_in      = count_ff;
      clear_pend_in = clear_pend_ff;
      push          = 1'b0;
      push_op.kind   = OP_ACC;
      push_op.clear  = cur_clear;
      push_op.digit  = dig.value;
      push_op.negate = cur_negate;
      push_op.count  = cur_count;

      if (accept) begin
         case (cur_phase)
            PH_DONE: begin
               phase_in = PH_DONE;
            end
            PH_SIGNS, PH_DIGITS: begin
               if (cur_phase == PH_SIGNS && is_sign) begin
                  phase_in      = PH_SIGNS;
                  negate_in     = cur_negate ^ (req_char_code == CHAR_MINUS);
                  count_in      = count_inc;
                  clear_pend_in = cur_clear;
               end else if (ends) begin
                  push          = 1'b1;
                  push_op.kind  = OP_EMIT;
                  phase_in      = PH_DONE;
                  negate_in     = cur_negate;
                  count_in      = cur_count;
                  clear_pend_in = 1'b0;
               end else begin
                  push          = 1'b1;
                  phase_in      = PH_DIGITS;
                  negate_in     = cur_negate;
                  count_in      = count_inc;
                  clear_pend_in = 1'b0;
               end
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_DONE;
         negate_ff     <= 1'b0;
         count_ff      <= '0;
         clear_pend_ff <= 1'b1;
      end else begin
         phase_ff      <= phase_in;
         negate_ff     <= negate_in;
         count_ff      <= count_in;
         clear_pend_ff <= clear_pend_in;
      end
   end

endmodule

// File: sv/rip_queue.sv
// Small operation queue between the front end and the accumulator.
module rip_queue
   import rip_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   input  logic   pop,
   output logic   empty,
   output op_type head_op
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   op_type        entries_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == FULL_COUNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head_op = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/rip_back.sv
// Back end: multiply-accumulate of digits and the registered result stage.
module rip_back
   import rip_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        op_valid,
   output logic        op_ready,
   input  op_type      op,
   input  logic [4:0]  radix,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_value_bits,
   output logic [15:0] rsp_end_offset
);

   logic [63:0] acc_ff, acc_in;
   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_value_ff, out_value_in;
   logic [15:0] out_count_ff, out_count_in;
   logic [63:0] base;
   logic        take;

   assign base     = op.clear ? '0 : acc_ff;
   assign op_ready = (op.kind == OP_ACC) || !out_valid_ff || rsp_ready;
   assign take     = op_valid && op_ready;

   assign rsp_valid      = out_valid_ff;
   assign rsp_value_bits = out_value_ff;
   assign rsp_end_offset = out_count_ff;

   always_comb begin
      acc_in       = acc_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_value_in = out_value_ff;
      out_count_in = out_count_ff;
      if (take) begin
         case (op.kind)
            OP_ACC: begin
               acc_in = 64'(base * 64'(radix)) + 64'(op.digit);
            end
            OP_EMIT: begin
               acc_in       = base;
               out_valid_in = 1'b1;
               out_value_in = op.negate ? 64'(64'd0 - base) : base;
               out_count_in = op.count;
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      out_value_ff <= out_value_in;
      out_count_ff <= out_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// File: sv/radix_integer_parser.sv
// Top level of the radix integer parser: configuration registers and the two halves.
//
// Characters enter on the req_ channel, one per transfer, with req_first marking
// the first character of a new string. A string ends at the first character that
// is not a digit below the radix (the NUL terminator included), leading signs in
// signed mode apart; that character produces one transfer on the rsp_ channel with
// the parsed 64-bit value and the count of consumed characters. All other characters
// produce no result. Throughput is one character per cycle while the queue is not
// full: the front end classifies each character in the cycle it is accepted, and
// the accumulator performs one multiply by the radix plus an add per cycle. A result
// goes first into the queue, then into the result register.
// When the receiver stalls, the result register holds its value; digit operations
// keep draining from the queue, and req_ready drops only once QUEUE_DEPTH
// operations are waiting behind a held result.
// Registers: radix at byte address 0 (reset 10), signed_mode at 4 (reset 1).
// Write them only while no string is in flight. Reset empties the queue and the
// result register and leaves the parser waiting for a start.
module radix_integer_parser
   import rip_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_first,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_value_bits,
   output logic [15:0] rsp_end_offset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [4:0]    radix_ff, radix_in;
   logic          signed_mode_ff, signed_mode_in;
   reg_index_type reg_sel;
   logic          wr_en;

   logic   queue_full, queue_empty;
   logic   push, pop;
   op_type push_op, head_op;
   logic   back_ready;

   assign pready  = 1'b1;
   assign reg_sel = reg_index_type'(paddr[2]);
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      radix_in       = radix_ff;
      signed_mode_in = signed_mode_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_RADIX:  radix_in       = pwdata[4:0];
            REG_SIGNED: signed_mode_in = pwdata[0];
            default:    radix_in       = radix_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_RADIX:  prdata = {27'd0, radix_ff};
         REG_SIGNED: prdata = {31'd0, signed_mode_ff};
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff       <= RADIX_RESET;
         signed_mode_ff <= SIGNED_RESET;
      end else begin
         radix_ff       <= radix_in;
         signed_mode_ff <= signed_mode_in;
      end
   end

   rip_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_first     (req_first),
      .radix         (radix_ff),
      .signed_mode   (signed_mode_ff),
      .queue_full    (queue_full),
      .push          (push),
      .push_op       (push_op)
   );

   rip_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .full    (queue_full),
      .pop     (pop),
      .empty   (queue_empty),
      .head_op (head_op)
   );

   assign pop = !queue_empty && back_ready;

   rip_back u_back (
      .clock          (clock),
      .reset          (reset),
      .op_valid       (!queue_empty),
      .op_ready       (back_ready),
      .op             (head_op),
      .radix          (radix_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value_bits (rsp_value_bits),
      .rsp_end_offset (rsp_end_offset)
   );

endmodule

// File: sim/radix_integer_parser_tb.sv
// Self-checking testbench for the radix integer parser.
`timescale 1ns / 1ps

module radix_integer_parser_tb;
   import rip_pkg::*;

   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 1200;
   localparam int LONG_DIGITS    = 100;
   localparam int NOT_HEX        = 255;
   localparam int REPORT_LIMIT   = 10;

   typedef enum logic [1:0] {
      PARSE_DONE,
      PARSE_SIGNS,
      PARSE_DIGITS
   } parse_phase_type;

   typedef struct {
      logic [63:0] value;
      logic [15:0] count;
   } parse_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code = 8'h00;
   logic        req_first = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_value_bits;
   logic [15:0] rsp_end_offset;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   // Shadow of the parser and its registers.
   logic [4:0]      cfg_radix = RADIX_RESET;
   logic            cfg_signed = SIGNED_RESET;
   parse_phase_type parse_phase = PARSE_DONE;
   logic [63:0]     parse_acc = '0;
   logic            parse_negate = 1'b0;
   logic [15:0]     parse_count = '0;

   parse_result_type parsed_results[$];
   int mismatch_count = 0;
   int items_sent = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;

   radix_integer_parser i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_code  (req_char_code),
      .req_first      (req_first),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value_bits (rsp_value_bits),
      .rsp_end_offset (rsp_end_offset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int hex_value(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      return NOT_HEX;
   endfunction

   function automatic logic [7:0] digit_char(input int v);
      if (v < 10) return 8'h30 + 8'(v);
      if ($urandom_range(1) == 1) return 8'h41 + 8'(v - 10);
      return 8'h61 + 8'(v - 10);
   endfunction

   // Advances the shadow parser by one character; returns 1 when it ends a string.
   function automatic logic parse_char(input logic [7:0] c, input logic f,
                                       output logic [63:0] value, output logic [15:0] count);
      int d;
      value = '0;
      count = '0;
      if (f) begin
         parse_acc = '0;
         parse_negate = 1'b0;
         parse_count = '0;
         parse_phase = cfg_signed ? PARSE_SIGNS : PARSE_DIGITS;
      end
      if (parse_phase == PARSE_DONE) return 1'b0;
      if (parse_phase == PARSE_SIGNS) begin
         if (c == CHAR_MINUS || c == CHAR_PLUS) begin
            if (c == CHAR_MINUS) parse_negate = ~parse_negate;
            if (parse_count != COUNT_MAX) parse_count++;
            return 1'b0;
         end
         parse_phase = PARSE_DIGITS;
      end
      d = hex_value(c);
      if (c == CHAR_NUL || d >= int'(cfg_radix)) begin
         value = parse_negate ? 64'd0 - parse_acc : parse_acc;
         count = parse_count;
         parse_phase = PARSE_DONE;
         return 1'b1;
      end
      parse_acc = parse_acc * 64'(cfg_radix) + 64'(d);
      if (parse_count != COUNT_MAX) parse_count++;
      return 1'b0;
   endfunction

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch in %s: expected %h, got %h at %0t", what, want, got, $realtime);
   endtask

   // Receiver: random stalls, and every result transfer checked against the oldest expectation.
   always @(posedge clock) begin
      parse_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (parsed_results.size() == 0) begin
            note_mismatch("unexpected result value", 64'd0, rsp_value_bits);
         end else begin
            want = parsed_results.pop_front();
            if (rsp_value_bits !== want.value)
               note_mismatch("value_bits", want.value, rsp_value_bits);
            if (rsp_end_offset !== want.count)
               note_mismatch("end_offset", 64'(want.count), 64'(rsp_end_offset));
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("FAIL radix_integer_parser");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_char(input logic [7:0] c, input logic f);
      logic [63:0] value;
      logic [15:0] count;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_char_code <= c;
      req_first <= f;
      do @(posedge clock); while (!req_ready);
      if (f || parse_phase != PARSE_DONE) items_sent++;
      if (parse_char(c, f, value, count)) parsed_results.push_back('{value, count});
   endtask

   task automatic send_text(input string s, input bit with_nul);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
      if (with_nul) send_char(CHAR_NUL, s.len() == 0);
   endtask

   // Holds the sender off until every expected result has come and the queue has drained.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (parsed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_RADIX:  cfg_radix = data[4:0];
         REG_SIGNED: cfg_signed = data[0];
         default:    cfg_radix = cfg_radix;
      endcase
   endtask

   task automatic csr_check(input reg_index_type idx, input logic [31:0] want);
      logic [31:0] got;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      if (got !== want) note_mismatch("register read", 64'(want), 64'(got));
   endtask

   task automatic set_config(input logic [4:0] radix, input logic signed_on);
      wait_idle();
      csr_write(REG_RADIX, 32'(radix));
      csr_write(REG_SIGNED, 32'(signed_on));
   endtask

   task automatic test_register_access();
      csr_check(REG_RADIX, 32'(RADIX_RESET));
      csr_check(REG_SIGNED, 32'(SIGNED_RESET));
      csr_write(REG_RADIX, 32'd16);
      csr_write(REG_SIGNED, 32'd0);
      csr_check(REG_RADIX, 32'd16);
      csr_check(REG_SIGNED, 32'd0);
      set_config(RADIX_RESET, SIGNED_RESET);
   endtask

   // Nothing may come out before the first start.
   task automatic test_before_start();
      send_char(8'h35, 1'b0);
      send_char(CHAR_NUL, 1'b0);
   endtask

   task automatic test_sign_runs();
      send_text("+-+-42", 1'b1);
      send_char(CHAR_MINUS, 1'b1);
      send_char(8'hFF, 1'b0);
      send_char(CHAR_NUL, 1'b1);
      // A new start abandons the unfinished string.
      send_text("12", 1'b0);
      send_text("3", 1'b1);
   endtask

   task automatic test_radix_edges();
      set_config(5'd16, 1'b0);
      send_text("fA9G", 1'b0);
      send_text("-1", 1'b0);
      set_config(5'd0, 1'b1);
      send_text("-5", 1'b0);
      set_config(5'd1, 1'b1);
      send_text("+0", 1'b1);
      set_config(5'd31, 1'b1);
      send_text("fF", 1'b1);
   endtask

   // Radix applies from the next character; the sign mode stays as sampled at the start.
   task automatic test_config_mid_string();
      set_config(5'd10, 1'b1);
      send_text("-1", 1'b0);
      set_config(5'd16, 1'b0);
      send_char(8'h66, 1'b0);
      send_char(CHAR_NUL, 1'b0);
   endtask

   // A long run of ones in base two carries the accumulator well past 64 bits.
   task automatic test_long_string();
      set_config(5'd2, 1'b1);
      send_char(CHAR_MINUS, 1'b1);
      for (int i = 0; i < LONG_DIGITS; i++) send_char(8'h31, 1'b0);
      send_char(CHAR_NUL, 1'b0);
   endtask

   task automatic random_string();
      int pool;
      int n;
      logic [7:0] c;
      bit lead;
      lead = 1'b1;
      pool = (cfg_radix > 16) ? 16 : int'(cfg_radix);
      if ($urandom_range(99) < 80) begin
         if (cfg_signed) begin
            n = $urandom_range(3);
            for (int i = 0; i < n; i++) begin
               send_char($urandom_range(1) ? CHAR_MINUS : CHAR_PLUS, lead);
               lead = 1'b0;
            end
         end
         n = (pool == 0) ? 0 : $urandom_range(20);
         for (int i = 0; i < n; i++) begin
            send_char(digit_char($urandom_range(pool - 1)), lead);
            lead = 1'b0;
         end
         // Some strings are left unfinished and get abandoned by the next start.
         if ($urandom_range(9) != 0) begin
            case ($urandom_range(2))
               0: c = CHAR_NUL;
               1: do c = 8'($urandom_range(255)); while (hex_value(c) < int'(cfg_radix));
               default: c = (pool < 16) ? digit_char($urandom_range(15, pool)) : CHAR_NUL;
            endcase
            send_char(c, lead);
         end
      end else begin
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++)
            send_char(8'($urandom_range(255)), $urandom_range(9) == 0);
      end
   endtask

   task automatic test_random_strings();
      int send_pcts[4] = '{0, 72, 0, 20};
      int recv_pcts[4] = '{0, 0, 72, 20};
      logic [4:0] edge_radix[8] = '{5'd0, 5'd1, 5'd2, 5'd8, 5'd10, 5'd16, 5'd17, 5'd31};
      int k;
      int target;
      for (int p = 0; p < 4; p++) begin
         for (int s = 0; s < 4; s++) begin
            k = p * 4 + s;
            if (k < 8) set_config(edge_radix[k], k[0]);
            else set_config(5'($urandom_range(16)), 1'($urandom_range(1)));
            send_idle_pct = send_pcts[p];
            recv_stall_pct = recv_pcts[p];
            target = items_sent + RANDOM_ITEMS / 16;
            while (items_sent < target) random_string();
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_access();
      test_before_start();
      test_sign_runs();
      test_radix_edges();
      test_config_mid_string();
      test_long_string();
      test_random_strings();
      wait_idle();
      if (mismatch_count == 0 && parsed_results.size() == 0) begin
         $display("PASS radix_integer_parser");
      end else begin
         $display("FAIL radix_integer_parser");
      end
      $finish;
   end

endmodule
